[hdl/cfpp_pkg.sv]
// ----------------------------------------------------------------------------
// cfpp_pkg
// shared types and constants for the crc framed packet parser
// ----------------------------------------------------------------------------
`default_nettype none

package cfpp_pkg;

    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_ID   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EXT_LAYOUT = 1'd1;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    localparam logic [1:0] KIND_HEADER  = 2'd0;
    localparam logic [1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [1:0] KIND_REPORT  = 2'd2;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_TOO_SHORT = 2'd1;
    localparam logic [1:0] STATUS_BAD_HDR   = 2'd2;
    localparam logic [1:0] STATUS_CRC_ERR   = 2'd3;

    typedef struct packed {
        logic [15:0] frame_id;
        logic        extended_layout;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  payload_byte;
        logic [1:0]  status;
        logic [7:0]  sequence_res;
        logic [7:0]  source_id;
        logic [7:0]  sub_id;
        logic [15:0] message_id;
        logic [15:0] payload_length;
        logic [7:0]  ext_code;
        logic [7:0]  ext_state;
    } res_t;

endpackage

`default_nettype wire

[hdl/cfpp_cfg_regs.sv]
// ----------------------------------------------------------------------------
// cfpp_cfg_regs
// configuration register file: expected frame id and header layout select
// ----------------------------------------------------------------------------
`default_nettype none

module cfpp_cfg_regs (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [cfpp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [15:0]                    cfg_data,
    output cfpp_pkg::cfg_t                      cfg
);

    logic [15:0] frame_id_reg;
    logic [15:0] frame_id_next;
    logic        ext_layout_reg;
    logic        ext_layout_next;

    assign cfg_ready = 1'b1;

    always_comb begin
        frame_id_next   = frame_id_reg;
        ext_layout_next = ext_layout_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                cfpp_pkg::REG_FRAME_ID:   frame_id_next   = cfg_data;
                cfpp_pkg::REG_EXT_LAYOUT: ext_layout_next = cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_id_reg   <= '0;
            ext_layout_reg <= 1'b0;
        end else begin
            frame_id_reg   <= frame_id_next;
            ext_layout_reg <= ext_layout_next;
        end
    end

    assign cfg.frame_id        = frame_id_reg;
    assign cfg.extended_layout = ext_layout_reg;

endmodule

`default_nettype wire

[hdl/cfpp_crc16.sv]
// ----------------------------------------------------------------------------
// cfpp_crc16
// one-byte update of a reflected crc-16 (modbus polynomial)
// ----------------------------------------------------------------------------
`default_nettype none

module cfpp_crc16 (
    input  wire logic [15:0] crc_in,
    input  wire logic [7:0]  data_in,
    output logic      [15:0] crc_out
);

    always_comb begin
        logic [15:0] c;
        c = crc_in ^ {8'h00, data_in};
        for (int n = 0; n < 8; n++) begin
            if (c[0]) begin
                c = (c >> 1) ^ cfpp_pkg::CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        crc_out = c;
    end

endmodule

`default_nettype wire

[hdl/cfpp_parser.sv]
// ----------------------------------------------------------------------------
// cfpp_parser
// per-byte header parse, crc tracking and frame report, one byte per step
// ----------------------------------------------------------------------------
`default_nettype none

module cfpp_parser #(
    parameter int ID_BYTES     = 2,
    parameter int LENGTH_BYTES = 2,
    parameter int MAX_DATAGRAM = 2048
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           step,
    input  wire logic [7:0]     byte_in,
    input  wire logic           last_in,
    input  wire cfpp_pkg::cfg_t cfg,
    output cfpp_pkg::res_t      res
);

    localparam int POS_W = $clog2(MAX_DATAGRAM + 1);
    localparam int CMP_W = ((POS_W > 17) ? POS_W : 17) + 1;

    localparam logic [POS_W-1:0] POS_MAX   = POS_W'(MAX_DATAGRAM);
    localparam logic [CMP_W-1:0] LEN_START = CMP_W'(ID_BYTES);
    localparam logic [CMP_W-1:0] EXT_START = CMP_W'(ID_BYTES + LENGTH_BYTES);

    logic [POS_W-1:0] pos_reg,  pos_next;
    logic [15:0]      crc_reg,  crc_next;
    logic             match_lo_reg, match_lo_next;
    logic             match_reg, match_next;
    logic             hdr_bad_reg, hdr_bad_next;
    logic [15:0]      len_reg,  len_next;
    logic [7:0]       seq_reg,  seq_next;
    logic [7:0]       source_reg, source_next;
    logic [7:0]       sub_reg,  sub_next;
    logic [15:0]      msg_reg,  msg_next;
    logic [15:0]      ext_reg,  ext_next;

    logic [15:0]      crc_upd;

    cfpp_crc16 u_crc (
        .crc_in  (crc_reg),
        .data_in (byte_in),
        .crc_out (crc_upd)
    );

    always_comb begin
        logic [CMP_W-1:0] pos_w;
        logic [CMP_W-1:0] q;
        logic [CMP_W-1:0] hdr;
        logic [CMP_W-1:0] pay_end;
        logic [CMP_W-1:0] lk;
        logic [CMP_W-1:0] ek;
        logic [CMP_W-1:0] total;
        logic [7:0]       want;

        pos_w   = CMP_W'(pos_reg);
        q       = EXT_START + (cfg.extended_layout ? CMP_W'(2) : CMP_W'(0));
        hdr     = q + CMP_W'(5);
        pay_end = hdr + CMP_W'(len_reg);
        lk      = pos_w - LEN_START;
        ek      = pos_w - EXT_START;
        want    = 8'h00;

        pos_next      = pos_reg;
        crc_next      = crc_reg;
        match_lo_next = match_lo_reg;
        match_next    = match_reg;
        hdr_bad_next  = hdr_bad_reg;
        len_next      = len_reg;
        seq_next      = seq_reg;
        source_next   = source_reg;
        sub_next      = sub_reg;
        msg_next      = msg_reg;
        ext_next      = ext_reg;

        res = '0;
        res.kind = cfpp_pkg::KIND_HEADER;

        if (pos_reg < POS_MAX) begin
            if (pos_w < LEN_START) begin
                if (pos_w < CMP_W'(2)) begin
                    want = pos_w[0] ? cfg.frame_id[15:8] : cfg.frame_id[7:0];
                end
                if (byte_in != want) begin
                    hdr_bad_next = 1'b1;
                end
                crc_next = crc_upd;
            end else if (pos_w < EXT_START) begin
                if (lk < CMP_W'(2)) begin
                    if (lk[0]) begin
                        len_next[15:8] = len_reg[15:8] | byte_in;
                    end else begin
                        len_next[7:0] = len_reg[7:0] | byte_in;
                    end
                end else if (byte_in != 8'h00) begin
                    len_next = 16'hFFFF;
                end
                crc_next = crc_upd;
            end else if (pos_w < hdr) begin
                if (pos_w < q) begin
                    if (ek[0]) begin
                        ext_next[15:8] = ext_reg[15:8] | byte_in;
                    end else begin
                        ext_next[7:0] = ext_reg[7:0] | byte_in;
                    end
                end else if (pos_w == q) begin
                    seq_next = byte_in;
                end else if (pos_w == q + CMP_W'(1)) begin
                    source_next = byte_in;
                end else if (pos_w == q + CMP_W'(2)) begin
                    sub_next = byte_in;
                end else if (pos_w == q + CMP_W'(3)) begin
                    msg_next[7:0] = byte_in;
                end else begin
                    msg_next[15:8] = byte_in;
                end
                crc_next = crc_upd;
            end else if (pos_w < pay_end) begin
                res.kind         = cfpp_pkg::KIND_PAYLOAD;
                res.payload_byte = byte_in;
                crc_next         = crc_upd;
            end else if (pos_w == pay_end) begin
                match_lo_next = (byte_in == crc_reg[7:0]);
            end else if (pos_w == pay_end + CMP_W'(1)) begin
                match_next = match_lo_reg && (byte_in == crc_reg[15:8]);
            end
            pos_next = pos_reg + POS_W'(1);
        end

        total = CMP_W'(pos_next);

        if (last_in) begin
            res = '0;
            res.kind = cfpp_pkg::KIND_REPORT;
            if (total < hdr + CMP_W'(2)) begin
                res.status = cfpp_pkg::STATUS_TOO_SHORT;
            end else if (hdr_bad_next) begin
                res.status = cfpp_pkg::STATUS_BAD_HDR;
            end else if (total < hdr + CMP_W'(2) + CMP_W'(len_next)) begin
                res.status = cfpp_pkg::STATUS_TOO_SHORT;
            end else if (match_next) begin
                res.status = cfpp_pkg::STATUS_OK;
            end else begin
                res.status = cfpp_pkg::STATUS_CRC_ERR;
            end
            res.sequence_res   = seq_next;
            res.source_id      = source_next;
            res.sub_id         = sub_next;
            res.message_id     = msg_next;
            res.payload_length = len_next;
            res.ext_code       = ext_next[7:0];
            res.ext_state      = ext_next[15:8];

            pos_next      = '0;
            crc_next      = cfpp_pkg::CRC_INIT;
            match_lo_next = 1'b0;
            match_next    = 1'b0;
            hdr_bad_next  = 1'b0;
            len_next      = '0;
            seq_next      = '0;
            source_next   = '0;
            sub_next      = '0;
            msg_next      = '0;
            ext_next      = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg      <= '0;
            crc_reg      <= cfpp_pkg::CRC_INIT;
            match_lo_reg <= 1'b0;
            match_reg    <= 1'b0;
            hdr_bad_reg  <= 1'b0;
            len_reg      <= '0;
            seq_reg      <= '0;
            source_reg   <= '0;
            sub_reg      <= '0;
            msg_reg      <= '0;
            ext_reg      <= '0;
        end else if (step) begin
            pos_reg      <= pos_next;
            crc_reg      <= crc_next;
            match_lo_reg <= match_lo_next;
            match_reg    <= match_next;
            hdr_bad_reg  <= hdr_bad_next;
            len_reg      <= len_next;
            seq_reg      <= seq_next;
            source_reg   <= source_next;
            sub_reg      <= sub_next;
            msg_reg      <= msg_next;
            ext_reg      <= ext_next;
        end
    end

endmodule

`default_nettype wire

[hdl/crc_framed_packet_parser_core.sv]
// ----------------------------------------------------------------------------
// crc_framed_packet_parser_core
// byte-serial datagram receiver with header parse and crc-16/modbus check
// timing: result is registered, valid in the cycle after the input transfer
// throughput: one byte per cycle while the result output is not stalled
// reset: synchronous active-low aresetn clears frame state, config and valid
// ----------------------------------------------------------------------------
`default_nettype none

module crc_framed_packet_parser_core #(
    parameter int ID_BYTES     = 2,
    parameter int LENGTH_BYTES = 2,
    parameter int MAX_DATAGRAM = 2048
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,

    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [cfpp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [15:0]                    cfg_data,

    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic [7:0]                     s_byte_in,
    input  wire logic                           s_end_of_datagram,

    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic [1:0]                          m_kind,
    output logic [7:0]                          m_payload_byte,
    output logic [1:0]                          m_status,
    output logic [7:0]                          m_sequence_res,
    output logic [7:0]                          m_source_id,
    output logic [7:0]                          m_sub_id,
    output logic [15:0]                         m_message_id,
    output logic [15:0]                         m_payload_length,
    output logic [7:0]                          m_ext_code,
    output logic [7:0]                          m_ext_state
);

    cfpp_pkg::cfg_t cfg;
    cfpp_pkg::res_t res;
    cfpp_pkg::res_t res_reg;
    logic           m_valid_reg;
    logic           step;

    cfpp_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    cfpp_parser #(
        .ID_BYTES     (ID_BYTES),
        .LENGTH_BYTES (LENGTH_BYTES),
        .MAX_DATAGRAM (MAX_DATAGRAM)
    ) u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .byte_in (s_byte_in),
        .last_in (s_end_of_datagram),
        .cfg     (cfg),
        .res     (res)
    );

    // result register frees up whenever it is empty or being drained
    assign s_ready = !m_valid_reg || m_ready;
    assign step    = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_ready) begin
            m_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            res_reg <= res;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_kind           = res_reg.kind;
    assign m_payload_byte   = res_reg.payload_byte;
    assign m_status         = res_reg.status;
    assign m_sequence_res   = res_reg.sequence_res;
    assign m_source_id      = res_reg.source_id;
    assign m_sub_id         = res_reg.sub_id;
    assign m_message_id     = res_reg.message_id;
    assign m_payload_length = res_reg.payload_length;
    assign m_ext_code       = res_reg.ext_code;
    assign m_ext_state      = res_reg.ext_state;

endmodule

`default_nettype wire
